// ===== rtl/sdu_pkg.sv =====
// ----------------------------------------------------------------------------
// sdu_pkg
// Shared types and constants of the scanline delta unfilter.
// ----------------------------------------------------------------------------
`default_nettype none

package sdu_pkg;

  // Result of the position tracker for one byte
  typedef struct packed {
    logic first_row;  // row above reads as zero
    logic row_head;   // first pixel of the row
    logic row_end;    // last byte of the row
  } pos_t;

  typedef struct packed {
    logic [7:0] coded_byte;
    logic [7:0] row_mode;
    logic       start_of_image;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       bad_mode;
    logic       row_end;
  } out_item_t;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CH_W       = 3;   // channel count register width
  localparam int IW_W       = 11;  // image width register width

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t REG_IMAGE_WIDTH    = 8'd0;
  localparam cfg_idx_t REG_PIXEL_CHANNELS = 8'd1;

  localparam logic [IW_W-1:0] IMAGE_WIDTH_RST    = 11'd1024;
  localparam logic [CH_W-1:0] PIXEL_CHANNELS_RST = 3'd4;

  localparam logic [7:0] MODE_LEFT = 8'd1;
  localparam logic [7:0] MODE_UP   = 8'd2;
  localparam logic [7:0] MODE_AVG  = 8'd4;

endpackage : sdu_pkg

`default_nettype wire

// ===== rtl/sdu_ram.sv =====
// ----------------------------------------------------------------------------
// sdu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sdu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                    wdata,
  input  wire logic                                re,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic      [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : sdu_ram

`default_nettype wire

// ===== rtl/sdu_colgen.sv =====
// ----------------------------------------------------------------------------
// sdu_colgen
// Configuration registers, row stride and byte column / first-row tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module sdu_colgen #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_CHANNELS = 4,
  localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire sdu_pkg::cfg_idx_t    cfg_idx,
  input  wire sdu_pkg::cfg_data_t   cfg_data,
  input  wire logic                 advance,
  input  wire logic                 start_of_image,
  output logic [sdu_pkg::CH_W-1:0]  ch,
  output logic [AW-1:0]             col,
  output sdu_pkg::pos_t             pos
);

  import sdu_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int SW = $clog2(DEPTH + 1);

  logic [IW_W-1:0] image_width_r;
  logic [CH_W-1:0] pixel_channels_r;
  logic [AW-1:0]   col_r;
  logic            first_r;

  logic [WW-1:0]   eff_w;
  logic [WW+2:0]   prod;
  logic [SW-1:0]   stride;
  logic [AW-1:0]   col_base;
  logic            first;
  logic [SW-1:0]   col_inc;

  // Clamp the registers into their legal ranges
  always_comb begin
    if (image_width_r == '0) begin
      eff_w = WW'(1);
    end else if (32'(image_width_r) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width_r);
    end
    if (pixel_channels_r == '0) begin
      ch = CH_W'(1);
    end else if (32'(pixel_channels_r) > 32'(MAX_CHANNELS)) begin
      ch = CH_W'(MAX_CHANNELS);
    end else begin
      ch = pixel_channels_r;
    end
  end

  assign prod   = (WW+3)'(eff_w) * (WW+3)'(ch);
  assign stride = SW'(prod);

  always_comb begin
    col_base      = start_of_image ? '0 : col_r;
    first         = start_of_image | first_r;
    col           = (SW'(col_base) >= stride) ? '0 : col_base;
    col_inc       = SW'(col) + SW'(1);
    pos.first_row = first;
    pos.row_head  = (32'(col) < 32'(ch));
    pos.row_end   = (col_inc >= stride);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r    <= IMAGE_WIDTH_RST;
      pixel_channels_r <= PIXEL_CHANNELS_RST;
      col_r            <= '0;
      first_r          <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_idx == REG_IMAGE_WIDTH) begin
        image_width_r <= cfg_data[IW_W-1:0];
        col_r         <= '0;
        first_r       <= 1'b1;
      end else if (cfg_idx == REG_PIXEL_CHANNELS) begin
        pixel_channels_r <= cfg_data[CH_W-1:0];
        col_r            <= '0;
        first_r          <= 1'b1;
      end
    end else if (advance) begin
      if (pos.row_end) begin
        col_r   <= '0;
        first_r <= 1'b0;
      end else begin
        col_r   <= col_inc[AW-1:0];
        first_r <= first;
      end
    end
  end

endmodule : sdu_colgen

`default_nettype wire

// ===== rtl/sdu_recon.sv =====
// ----------------------------------------------------------------------------
// sdu_recon
// Left-neighbor history and the left / up / average reconstruction.
// ----------------------------------------------------------------------------
`default_nettype none

module sdu_recon #(
  parameter int MAX_CHANNELS = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 clear,
  input  wire logic                 advance,
  input  wire logic [sdu_pkg::CH_W-1:0] ch,
  input  wire logic [7:0]           above_raw,
  input  wire logic [7:0]           coded_byte,
  input  wire logic [7:0]           row_mode,
  input  wire sdu_pkg::pos_t        pos,
  output logic      [7:0]           result,
  output logic                      bad
);

  import sdu_pkg::*;

  localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [7:0]      hist_r [MAX_CHANNELS];
  logic [CH_W-1:0] ch_m1;
  logic [7:0]      left;
  logic [7:0]      above;
  logic [8:0]      sum;

  assign ch_m1 = ch - CH_W'(1);
  assign left  = hist_r[ch_m1[CW-1:0]];
  assign above = pos.first_row ? 8'd0 : above_raw;
  assign sum   = {1'b0, above} + {1'b0, left};

  always_comb begin
    bad = 1'b0;
    case (row_mode)
      MODE_LEFT: result = pos.row_head ? coded_byte : left - coded_byte;
      MODE_UP:   result = above - coded_byte;
      MODE_AVG:  result = pos.row_head ? coded_byte : sum[8:1] - coded_byte;
      default: begin
        result = coded_byte;
        bad    = 1'b1;
      end
    endcase
  end

  // Shift the newest byte in at the head of the history
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        hist_r[i] <= 8'd0;
      end
    end else if (advance) begin
      hist_r[0] <= result;
      for (int i = 1; i < MAX_CHANNELS; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

endmodule : sdu_recon

`default_nettype wire

// ===== rtl/scanline_delta_unfilter.sv =====
// ----------------------------------------------------------------------------
// scanline_delta_unfilter
// An input transfer loads stage 1; stage 1 loads the output register, which
// drives out_*, once that register is free or being taken.
// Throughput: one byte per cycle while the sink takes every result; the line store reads and writes on separate
// ports in the same cycle.
// Reset (rst_n low, synchronous): width 1024, 4 channels, row 0 column 0,
// history zeroed; the line store itself is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

// Rebuilds row-delta filtered image bytes (left, up, average predictors).
// Stage 0 (transfer): column/row tracking, line store read of the byte above.
// Stage 1: predictor arithmetic, write back to the line store, history shift.
// Output register: holds a result while the sink stalls; stage 1 keeps
// working as long as the output register is empty or being drained.
module scanline_delta_unfilter #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_CHANNELS = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire sdu_pkg::in_item_t   in_data,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output sdu_pkg::out_item_t       out_data,
  // configuration write channel
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire sdu_pkg::cfg_idx_t   cfg_index,
  input  wire sdu_pkg::cfg_data_t  cfg_data
);

  import sdu_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // handshakes
  logic            in_xfer;
  logic            cfg_xfer;
  logic            cfg_restart;
  logic            s1_adv;

  // stage 0
  logic [CH_W-1:0] ch;
  logic [AW-1:0]   col;
  pos_t            pos;

  // stage 1
  logic            s1_valid_r;
  logic [7:0]      s1_coded_r;
  logic [7:0]      s1_mode_r;
  pos_t            s1_pos_r;
  logic [AW-1:0]   s1_col_r;
  logic            s1_byp_r;
  logic [7:0]      s1_byp_data_r;
  logic [7:0]      ram_rdata;
  logic [7:0]      above;
  logic [7:0]      result;
  logic            bad;

  // output register
  logic            out_valid_r;
  out_item_t       out_item_r;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid & cfg_ready;

  // Only a write to a mapped register restarts the position and history
  assign cfg_restart = cfg_xfer & ((cfg_index == REG_IMAGE_WIDTH) |
                                   (cfg_index == REG_PIXEL_CHANNELS));

  // Stage 1 drains when the output register is free or being taken
  assign s1_adv   = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | s1_adv;
  assign in_xfer  = in_valid & in_ready;

  sdu_colgen #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_colgen (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_xfer),
    .cfg_idx        (cfg_index),
    .cfg_data       (cfg_data),
    .advance        (in_xfer),
    .start_of_image (in_data.start_of_image),
    .ch             (ch),
    .col            (col),
    .pos            (pos)
  );

  // Line store: read the byte above on transfer, write the result back
  // from stage 1 at its own column.
  sdu_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (result),
    .re    (in_xfer),
    .raddr (col),
    .rdata (ram_rdata)
  );

  // With a one-byte row the read and the write of the same entry land in
  // the same cycle: capture the write data and forward it.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_coded_r    <= in_data.coded_byte;
      s1_mode_r     <= in_data.row_mode;
      s1_pos_r      <= pos;
      s1_col_r      <= col;
      s1_byp_r      <= s1_adv & (s1_col_r == col);
      s1_byp_data_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  assign above = s1_byp_r ? s1_byp_data_r : ram_rdata;

  sdu_recon #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_recon (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (cfg_restart),
    .advance    (s1_adv),
    .ch         (ch),
    .above_raw  (above),
    .coded_byte (s1_coded_r),
    .row_mode   (s1_mode_r),
    .pos        (s1_pos_r),
    .result     (result),
    .bad        (bad)
  );

  // Output register: load on stage 1 advance, drop after the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item_r.pixel_byte <= result;
      out_item_r.bad_mode   <= bad;
      out_item_r.row_end    <= s1_pos_r.row_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule : scanline_delta_unfilter

`default_nettype wire

// ===== verif/scanline_delta_unfilter_tb.sv =====
// ----------------------------------------------------------------------------
// scanline_delta_unfilter_tb
// Self-checking bench for the scanline delta unfilter. It streams coded bytes
// through the valid/ready input, and an in-bench rebuild of the left, up and
// average predictors checks every returned pixel byte, bad-mode flag and
// row-end flag in order. The run steps through several row geometries from
// one byte per row up to the widest row, with random stalls on both sides.
// ----------------------------------------------------------------------------
module scanline_delta_unfilter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdu_pkg::*;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_CHANNELS = 4;
  localparam int STORE_DEPTH  = MAX_WIDTH * MAX_CHANNELS;
  localparam int HIST_DEPTH   = 4;
  localparam int IDLE_PCT     = 37;   // percent of cycles each side sits idle
  localparam int DRAIN_CYCLES = 8;    // tail after the last result

  // Index that decodes to no register; a write there must change nothing
  localparam cfg_idx_t REG_UNMAPPED = 8'hFF;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_idx_t  cfg_index = '0;
  cfg_data_t cfg_data  = '0;

  // Coded bytes waiting for the driver, and the pixels they must rebuild to
  in_item_t  coded_queue[$];
  out_item_t expected_pixels[$];
  out_item_t oldest_pixel;

  // Mirror of the block: line store, left history, position, registers
  bit   [7:0]      line_mem [STORE_DEPTH];
  logic [7:0]      left_hist [HIST_DEPTH];
  logic [11:0]     col_pos;
  logic            first_row;
  logic [IW_W-1:0] width_reg;
  logic [CH_W-1:0] chan_reg;

  // Stream generator position, kept across calls so a phase can be split
  int         gen_col;
  int         gen_rows_left;
  logic [7:0] gen_mode;

  logic no_idle = 1'b0;
  int   error_count     = 0;
  int   results_checked = 0;
  int   bad_mode_seen   = 0;
  int   row_ends_seen   = 0;
  int   settings_count  = 0;

  scanline_delta_unfilter #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register values as the datapath sees them: zero means one, clamp above max
  function automatic int pixels_per_row();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int bytes_per_pixel();
    if (chan_reg == 0) return 1;
    if (chan_reg > MAX_CHANNELS) return MAX_CHANNELS;
    return int'(chan_reg);
  endfunction

  function automatic int row_stride();
    return pixels_per_row() * bytes_per_pixel();
  endfunction

  // Back to row 0, column 0 with the left history cleared
  function automatic void restart_position();
    int i;
    for (i = 0; i < HIST_DEPTH; i++) left_hist[i] = 8'h00;
    col_pos   = '0;
    first_row = 1'b1;
  endfunction

  // Rebuild one byte and advance the mirrored position and history
  function automatic out_item_t unfilter_byte(input in_item_t item);
    out_item_t  res;
    int         stride;
    int         ch;
    int         col;
    int         i;
    logic [7:0] above;
    logic [7:0] left;
    logic [8:0] pair_sum;
    logic       row_head;
    ch     = bytes_per_pixel();
    stride = row_stride();
    if (item.start_of_image) begin
      col_pos   = '0;
      first_row = 1'b1;
    end
    col = int'(col_pos);
    if (col >= stride) col = 0;
    // The top row has nothing above it: read zeros instead of the store
    above    = first_row ? 8'h00 : line_mem[col];
    left     = left_hist[ch-1];
    row_head = (col < ch);
    res.bad_mode = 1'b0;
    case (item.row_mode)
      MODE_LEFT: begin
        res.pixel_byte = row_head ? item.coded_byte : left - item.coded_byte;
      end
      MODE_UP: begin
        res.pixel_byte = above - item.coded_byte;
      end
      MODE_AVG: begin
        pair_sum       = {1'b0, above} + {1'b0, left};
        res.pixel_byte = row_head ? item.coded_byte : pair_sum[8:1] - item.coded_byte;
      end
      default: begin
        // Unknown mode: pass the byte through and flag it
        res.pixel_byte = item.coded_byte;
        res.bad_mode   = 1'b1;
      end
    endcase
    line_mem[col] = res.pixel_byte;
    for (i = HIST_DEPTH - 1; i > 0; i--) left_hist[i] = left_hist[i-1];
    left_hist[0] = res.pixel_byte;
    res.row_end = (col + 1 >= stride);
    if (res.row_end) begin
      col_pos   = '0;
      first_row = 1'b0;
    end else begin
      col_pos = 12'(col + 1);
    end
    return res;
  endfunction

  function automatic logic [7:0] pick_row_mode();
    int         roll;
    logic [7:0] mode;
    roll = $urandom_range(0, 99);
    if (roll < 30) return MODE_LEFT;
    if (roll < 60) return MODE_UP;
    if (roll < 90) return MODE_AVG;
    do mode = 8'($urandom_range(0, 255));
    while (mode == MODE_LEFT || mode == MODE_UP || mode == MODE_AVG);
    return mode;
  endfunction

  task automatic push_item(input logic [7:0] coded, input logic [7:0] mode, input logic sof);
    in_item_t item;
    item.coded_byte     = coded;
    item.row_mode       = mode;
    item.start_of_image = sof;
    coded_queue.push_back(item);
  endtask

  // Queue well-formed images (one mode per row, start flag on the first
  // byte) with random content; noise_pct of the bytes get a flipped start
  // flag or a stray mode to break the framing.
  task automatic queue_stream(input int count, input int noise_pct);
    in_item_t item;
    int       stride;
    int       n;
    stride = row_stride();
    for (n = 0; n < count; n++) begin
      item.start_of_image = 1'b0;
      if (gen_col == 0) begin
        if (gen_rows_left == 0) begin
          gen_rows_left       = $urandom_range(1, 5);
          item.start_of_image = 1'b1;
        end
        gen_mode = pick_row_mode();
      end
      item.coded_byte = 8'($urandom_range(0, 255));
      item.row_mode   = gen_mode;
      if ($urandom_range(0, 99) < noise_pct) item.start_of_image = ~item.start_of_image;
      if ($urandom_range(0, 99) < noise_pct) item.row_mode = 8'($urandom_range(0, 255));
      coded_queue.push_back(item);
      gen_col++;
      if (gen_col >= stride) begin
        gen_col = 0;
        gen_rows_left--;
      end
    end
  endtask

  // Hold until every queued byte is sent and every pixel is back. Sample at
  // the falling edge so the clocked processes have all settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (coded_queue.size() != 0 || in_valid || expected_pixels.size() != 0);
  endtask

  // One register transfer; the mirror takes the value at the same edge
  task automatic program_reg(input cfg_idx_t idx, input cfg_data_t value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_IMAGE_WIDTH || idx == REG_PIXEL_CHANNELS) begin
      if (idx == REG_IMAGE_WIDTH) width_reg = value[IW_W-1:0];
      else chan_reg = value[CH_W-1:0];
      restart_position();
      gen_col       = 0;
      gen_rows_left = 0;
    end
  endtask

  // New geometry between phases; the bits above each field are random junk
  task automatic apply_setting(input int width, input int channels);
    cfg_data_t width_word;
    cfg_data_t chan_word;
    width_word             = cfg_data_t'($urandom);
    width_word[IW_W-1:0]   = IW_W'(width);
    chan_word              = cfg_data_t'($urandom);
    chan_word[CH_W-1:0]    = CH_W'(channels);
    wait_idle();
    program_reg(REG_IMAGE_WIDTH, width_word);
    program_reg(REG_PIXEL_CHANNELS, chan_word);
    settings_count++;
  endtask

  task automatic flag_mismatch(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    error_count++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  // Driver: predict each byte on its transfer, then offer the next one
  // unless this cycle idles. Valid drops only when nothing is offered.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_pixels.push_back(unfilter_byte(in_data));
      if (!in_valid || in_ready) begin
        if (coded_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_data  <= coded_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        end else begin
          oldest_pixel = expected_pixels.pop_front();
          if (out_data.pixel_byte !== oldest_pixel.pixel_byte)
            flag_mismatch("pixel_byte", oldest_pixel.pixel_byte, out_data.pixel_byte);
          if (out_data.bad_mode !== oldest_pixel.bad_mode)
            flag_mismatch("bad_mode", 8'(oldest_pixel.bad_mode), 8'(out_data.bad_mode));
          if (out_data.row_end !== oldest_pixel.row_end)
            flag_mismatch("row_end", 8'(oldest_pixel.row_end), 8'(out_data.row_end));
          results_checked++;
          if (oldest_pixel.bad_mode) bad_mode_seen++;
          if (oldest_pixel.row_end) row_ends_seen++;
        end
      end
      out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    width_reg     = IMAGE_WIDTH_RST;
    chan_reg      = PIXEL_CHANNELS_RST;
    gen_col       = 0;
    gen_rows_left = 0;
    gen_mode      = MODE_LEFT;
    restart_position();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset geometry (1024 pixels of 4 bytes), top row: the first pixel
    // passes in left and average mode, up mode subtracts from zero, and
    // both extremes of the mode byte are rejected.
    push_item(8'h00, MODE_LEFT, 1'b1);
    push_item(8'hFF, MODE_UP,   1'b0);
    push_item(8'h80, MODE_AVG,  1'b0);
    push_item(8'h01, 8'h00,     1'b0);
    push_item(8'h7F, 8'hFF,     1'b0);
    push_item(8'h10, MODE_LEFT, 1'b0);
    push_item(8'h22, MODE_AVG,  1'b0);

    // Two pixels of two bytes: one row per mode so up and average see a
    // real row above, then a restart in the middle of a row.
    apply_setting(2, 2);
    push_item(8'hFF, MODE_LEFT, 1'b1);
    push_item(8'h00, MODE_LEFT, 1'b0);
    push_item(8'h0A, MODE_LEFT, 1'b0);
    push_item(8'h14, MODE_LEFT, 1'b0);
    push_item(8'h00, MODE_UP,   1'b0);
    push_item(8'hFF, MODE_UP,   1'b0);
    push_item(8'h01, MODE_UP,   1'b0);
    push_item(8'h02, MODE_UP,   1'b0);
    push_item(8'h03, MODE_AVG,  1'b0);
    push_item(8'h04, MODE_AVG,  1'b0);
    push_item(8'hFF, MODE_AVG,  1'b0);
    push_item(8'h00, MODE_AVG,  1'b0);
    push_item(8'hAA, 8'h03,     1'b0);
    push_item(8'h55, 8'h03,     1'b0);
    push_item(8'h00, 8'h03,     1'b0);
    push_item(8'hFF, 8'h03,     1'b0);
    push_item(8'h05, MODE_LEFT, 1'b0);
    push_item(8'h06, MODE_LEFT, 1'b0);
    push_item(8'h07, MODE_UP,   1'b1);
    push_item(8'h08, MODE_UP,   1'b0);

    // Random phases over small geometries
    apply_setting(3, 3);
    queue_stream(110, 6);
    apply_setting(1, 1);
    queue_stream(40, 6);
    apply_setting(0, 7);
    queue_stream(40, 6);

    // Back-to-back stretch: neither side idles
    apply_setting(5, 2);
    no_idle = 1'b1;
    queue_stream(120, 4);
    wait_idle();
    no_idle = 1'b0;

    // Stall the sender until everything is back, poke an unmapped register
    // (position must carry on), then resume the same images.
    apply_setting(16, 4);
    queue_stream(70, 5);
    wait_idle();
    program_reg(REG_UNMAPPED, cfg_data_t'($urandom));
    queue_stream(70, 5);

    apply_setting(7, 0);
    queue_stream(70, 6);

    // Widest row with single-byte pixels: width clamps to the maximum, walk
    // the top row to just past its middle
    apply_setting(2047, 0);
    queue_stream(520, 0);

    // Largest stride, only the start of the top row
    apply_setting(1024, 4);
    queue_stream(40, 4);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d pixel bytes over %0d row geometries: %0d with a bad mode, %0d row ends.",
             results_checked, settings_count + 1, bad_mode_seen, row_ends_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches in total", error_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, expected_pixels.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule : scanline_delta_unfilter_tb

// ===== filelist.f =====
rtl/sdu_pkg.sv
rtl/sdu_ram.sv
rtl/sdu_colgen.sv
rtl/sdu_recon.sv
rtl/scanline_delta_unfilter.sv
verif/scanline_delta_unfilter_tb.sv
